FILE: src/ini_config_tokenizer_core_defines.svh
// assertion macros shared by the tokenizer rtl
// expects clk and rst_n in the scope of each use
`ifndef INI_CONFIG_TOKENIZER_CORE_DEFINES_SVH
`define INI_CONFIG_TOKENIZER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ICT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ICT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ict_pkg.sv
// shared types and constants of the ini config tokenizer
// no dependencies
`default_nettype none

package ict_pkg;

    typedef enum logic [3:0]
    {
        PH_TOP,
        PH_HDR_PRE,
        PH_HDR_NAME,
        PH_HDR_POST,
        PH_NAME,
        PH_NAME_POST,
        PH_VAL_PRE,
        PH_VALUE,
        PH_ESC,
        PH_COMMENT
    } phase_t;

    typedef struct packed
    {
        phase_t        phase;
        logic [11:0]   tok_len;
        logic [23:0]   line;
        logic [15:0]   col;
        logic [31:0]   bytes;
        logic          failed;
    } parse_state_t;

    localparam parse_state_t PARSE_STATE_RESET = '{
        phase:   PH_TOP,
        tok_len: 12'd0,
        line:    24'd1,
        col:     16'd0,
        bytes:   32'd0,
        failed:  1'b0
    };

    typedef struct packed
    {
        logic [2:0]  kind;
        logic [7:0]  ch;
        logic [2:0]  code;
        logic [23:0] line;
        logic [15:0] col;
        logic [31:0] bytes;
        logic        last;
    } result_t;

    typedef struct packed
    {
        logic [7:0]  sec;
        logic [7:0]  name;
        logic [11:0] value;
    } limits_t;

    // register indexes on the config port
    localparam logic [1:0] REG_IDX_SECTION = 2'd0;
    localparam logic [1:0] REG_IDX_NAME    = 2'd1;
    localparam logic [1:0] REG_IDX_VALUE   = 2'd2;

    localparam limits_t LIMITS_RESET = '{sec: 8'd64, name: 8'd64, value: 12'd1024};

    localparam int RES_DEPTH = 4;
    localparam int PTR_W     = $clog2(RES_DEPTH);
    localparam int CNT_W     = $clog2(RES_DEPTH + 1);

endpackage

`default_nettype wire

FILE: src/ict_step.sv
// per-byte parse step: next state and up to two results
// depends on ict_pkg
`default_nettype none

module ict_step
    import ict_pkg::*;
(
    input  parse_state_t cur,
    input  logic         func,
    input  logic [7:0]   data_byte,
    input  limits_t      limits,
    output parse_state_t nxt,
    output logic [1:0]   res_n,
    output result_t      res0,
    output result_t      res1
);

    localparam logic [2:0] KIND_SEC_CHAR   = 3'd0;
    localparam logic [2:0] KIND_SEC_END    = 3'd1;
    localparam logic [2:0] KIND_NAME_CHAR  = 3'd2;
    localparam logic [2:0] KIND_VAL_CHAR   = 3'd3;
    localparam logic [2:0] KIND_ENTRY_END  = 3'd4;
    localparam logic [2:0] KIND_ERROR      = 3'd5;
    localparam logic [2:0] KIND_DONE       = 3'd6;

    localparam logic [2:0] ERR_ILLEGAL     = 3'd0;
    localparam logic [2:0] ERR_EQUALS      = 3'd1;
    localparam logic [2:0] ERR_QUOTE       = 3'd2;
    localparam logic [2:0] ERR_TOO_LONG    = 3'd3;
    localparam logic [2:0] ERR_HEADER      = 3'd4;

    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_VT     = 8'h0B;

    function automatic logic is_ws(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR
            || c == CH_FF || c == CH_VT;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_cont(input logic [7:0] c);
        return is_letter(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER;
    endfunction

    function automatic result_t mk_res(input logic [2:0] kind, input logic [7:0] ch,
                                       input logic [2:0] code, input parse_state_t st,
                                       input logic last);
        result_t r;
        r.kind  = kind;
        r.ch    = ch;
        r.code  = code;
        r.line  = st.line;
        r.col   = st.col;
        r.bytes = st.bytes;
        r.last  = last;
        return r;
    endfunction

    logic        do_push;
    logic [2:0]  push_kind;
    logic [11:0] push_lim;
    logic [11:0] tl_base;
    logic        err;
    logic [2:0]  err_code;
    logic        emit;
    logic [2:0]  emit_kind;
    logic [7:0]  emit_ch;

    always_comb
    begin
        nxt       = cur;
        res_n     = 2'd0;
        res0      = '0;
        res1      = '0;
        do_push   = 1'b0;
        push_kind = KIND_SEC_CHAR;
        push_lim  = 12'd0;
        tl_base   = cur.tok_len;
        err       = 1'b0;
        err_code  = ERR_ILLEGAL;
        emit      = 1'b0;
        emit_kind = KIND_SEC_END;
        emit_ch   = 8'd0;

        if (func)
        begin
            if (!cur.failed)
            begin
                case (cur.phase)
                    PH_TOP, PH_COMMENT:
                        err = 1'b0;
                    PH_HDR_PRE, PH_HDR_NAME, PH_HDR_POST:
                    begin
                        err      = 1'b1;
                        err_code = ERR_HEADER;
                    end
                    PH_NAME, PH_NAME_POST:
                    begin
                        err      = 1'b1;
                        err_code = ERR_EQUALS;
                    end
                    default:
                    begin
                        err      = 1'b1;
                        err_code = ERR_QUOTE;
                    end
                endcase
            end
            if (err)
            begin
                res0  = mk_res(KIND_ERROR, 8'd0, err_code, cur, 1'b0);
                res1  = mk_res(KIND_DONE, 8'd0, ERR_ILLEGAL, cur, 1'b1);
                res_n = 2'd2;
            end
            else
            begin
                res0  = mk_res(KIND_DONE, 8'd0, ERR_ILLEGAL, cur, 1'b1);
                res_n = 2'd1;
            end
            nxt = PARSE_STATE_RESET;
        end
        else if (!cur.failed)
        begin
            // saturating position counters
            if (cur.bytes != '1)
                nxt.bytes = cur.bytes + 32'd1;
            if (cur.col != '1)
                nxt.col = cur.col + 16'd1;
            if (data_byte == CH_NL)
            begin
                if (cur.line != '1)
                    nxt.line = cur.line + 24'd1;
                nxt.col = 16'd0;
            end

            case (cur.phase)
                PH_TOP:
                begin
                    if (is_ws(data_byte))
                        nxt.phase = PH_TOP;
                    else if (data_byte == CH_LBRACK)
                        nxt.phase = PH_HDR_PRE;
                    else if (data_byte == CH_HASH)
                        nxt.phase = PH_COMMENT;
                    else if (is_letter(data_byte))
                    begin
                        nxt.phase   = PH_NAME;
                        nxt.tok_len = 12'd0;
                        tl_base     = 12'd0;
                        do_push     = 1'b1;
                        push_kind   = KIND_NAME_CHAR;
                        push_lim    = {4'd0, limits.name};
                    end
                    else
                    begin
                        err      = 1'b1;
                        err_code = ERR_ILLEGAL;
                    end
                end
                PH_HDR_PRE:
                begin
                    if (is_ws(data_byte))
                        nxt.phase = PH_HDR_PRE;
                    else if (is_letter(data_byte))
                    begin
                        nxt.phase   = PH_HDR_NAME;
                        nxt.tok_len = 12'd0;
                        tl_base     = 12'd0;
                        do_push     = 1'b1;
                        push_kind   = KIND_SEC_CHAR;
                        push_lim    = {4'd0, limits.sec};
                    end
                    else
                    begin
                        err      = 1'b1;
                        err_code = ERR_HEADER;
                    end
                end
                PH_HDR_NAME, PH_HDR_POST:
                begin
                    if (cur.phase == PH_HDR_NAME && is_cont(data_byte))
                    begin
                        do_push   = 1'b1;
                        push_kind = KIND_SEC_CHAR;
                        push_lim  = {4'd0, limits.sec};
                    end
                    else if (is_ws(data_byte))
                        nxt.phase = PH_HDR_POST;
                    else if (data_byte == CH_RBRACK)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_SEC_END;
                        nxt.phase = PH_TOP;
                    end
                    else
                    begin
                        err      = 1'b1;
                        err_code = ERR_HEADER;
                    end
                end
                PH_NAME, PH_NAME_POST:
                begin
                    if (cur.phase == PH_NAME && is_cont(data_byte))
                    begin
                        do_push   = 1'b1;
                        push_kind = KIND_NAME_CHAR;
                        push_lim  = {4'd0, limits.name};
                    end
                    else if (is_ws(data_byte))
                        nxt.phase = PH_NAME_POST;
                    else if (data_byte == CH_EQ)
                        nxt.phase = PH_VAL_PRE;
                    else
                    begin
                        err      = 1'b1;
                        err_code = ERR_EQUALS;
                    end
                end
                PH_VAL_PRE:
                begin
                    if (is_ws(data_byte))
                        nxt.phase = PH_VAL_PRE;
                    else if (data_byte == CH_QUOTE)
                    begin
                        nxt.tok_len = 12'd0;
                        nxt.phase   = PH_VALUE;
                    end
                    else
                    begin
                        err      = 1'b1;
                        err_code = ERR_QUOTE;
                    end
                end
                PH_VALUE:
                begin
                    if (data_byte == CH_BSLASH)
                        nxt.phase = PH_ESC;
                    else if (data_byte == CH_QUOTE)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_ENTRY_END;
                        nxt.phase = PH_TOP;
                    end
                    else
                    begin
                        do_push   = 1'b1;
                        push_kind = KIND_VAL_CHAR;
                        push_lim  = limits.value;
                    end
                end
                PH_ESC:
                begin
                    if (data_byte == CH_BSLASH || data_byte == CH_QUOTE)
                    begin
                        nxt.phase = PH_VALUE;
                        do_push   = 1'b1;
                        push_kind = KIND_VAL_CHAR;
                        push_lim  = limits.value;
                    end
                    else
                    begin
                        err      = 1'b1;
                        err_code = ERR_ILLEGAL;
                    end
                end
                default:
                begin
                    if (data_byte == CH_NL)
                        nxt.phase = PH_TOP;
                    else
                        nxt.phase = PH_COMMENT;
                end
            endcase

            // token character against its length limit
            if (do_push)
            begin
                if (tl_base < push_lim)
                begin
                    nxt.tok_len = tl_base + 12'd1;
                    emit        = 1'b1;
                    emit_kind   = push_kind;
                    emit_ch     = data_byte;
                end
                else
                begin
                    err      = 1'b1;
                    err_code = ERR_TOO_LONG;
                end
            end

            if (err)
            begin
                nxt.failed = 1'b1;
                res0       = mk_res(KIND_ERROR, 8'd0, err_code, nxt, 1'b1);
                res_n      = 2'd1;
            end
            else if (emit)
            begin
                res0  = mk_res(emit_kind, emit_ch, ERR_ILLEGAL, nxt, 1'b1);
                res_n = 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/ict_res_fifo.sv
// small result queue, takes up to two results per cycle, gives one
// depends on ict_pkg and the assertion macro header
`default_nettype none
`include "ini_config_tokenizer_core_defines.svh"

module ict_res_fifo
    import ict_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_n,
    input  result_t    push0,
    input  result_t    push1,
    output logic       room,
    output result_t    head,
    output logic       head_valid,
    input  logic       head_ready
);

    result_t            mem [RES_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               pop;

    assign head_valid = count_reg != '0;
    assign head       = mem[rd_ptr_reg];
    assign pop        = head_valid && head_ready;
    // room for a full end-of-stream pair whatever the receiver does
    assign room       = count_reg <= CNT_W'(RES_DEPTH - 2);

    always_comb
    begin
        wr_ptr_next = PTR_W'(wr_ptr_reg + PTR_W'(push_n));
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        count_next  = CNT_W'(count_reg + CNT_W'(push_n) - CNT_W'(pop));
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem[wr_ptr_reg] <= push0;
        if (push_n == 2'd2)
            mem[PTR_W'(wr_ptr_reg + PTR_W'(1))] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ICT_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(RES_DEPTH), "result queue overfilled")
    `ICT_ASSERT_SAME(a_no_overflow, push_n != 2'd0, (count_reg + CNT_W'(push_n)) <= CNT_W'(RES_DEPTH), "push into full result queue")
    `ICT_ASSERT_NEXT(a_pair_grows, push_n == 2'd2 && !pop, count_reg == CNT_W'($past(count_reg) + CNT_W'(2)), "pair push lost an entry")

endmodule

`default_nettype wire

FILE: src/ini_config_tokenizer_core.sv
// top level of the ini config tokenizer: apb registers, parse state, result queue
// depends on ict_pkg, ict_step, ict_res_fifo and the assertion macro header
`default_nettype none
`include "ini_config_tokenizer_core_defines.svh"

// usage
// item channel (item_valid/item_ready): one transaction per input byte (func 0)
// or end of stream (func 1). result channel (result_valid/result_ready): one
// transaction per event, last_of_run marks the final event of a byte.
// a byte is parsed in the cycle it is accepted and its event is written to a
// four-entry result queue, whose head drives the result channel; one byte per
// cycle is taken as long as the receiver keeps up. end of stream may give two
// events (error, then done).
// item_ready drops only when the queue holds more than two events, so a
// stalled receiver holds the input back once three events wait; from an
// empty queue that takes three transactions that each give an event.
// limit registers sit at byte addresses 0, 4 and 8 of the apb port; write
// them only while the block is idle.
// reset clears the parse state to top level, line 1, column 0, offset 0,
// empties the queue and loads the limits with 64, 64 and 1024. after end of
// stream the parse state returns to that reset value by itself.
module ini_config_tokenizer_core
    import ict_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_ready,
    input  logic        func,
    input  logic [7:0]  data_byte,

    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  kind,
    output logic [7:0]  out_char,
    output logic [2:0]  error_code,
    output logic [23:0] line_number,
    output logic [15:0] column_number,
    output logic [31:0] byte_offset,
    output logic        last_of_run,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t step_nxt;
    limits_t      limits_reg;
    limits_t      limits_next;
    logic [1:0]   step_res_n;
    result_t      step_res0;
    result_t      step_res1;
    logic [1:0]   push_n;
    logic         accept;
    logic         cfg_write;
    result_t      head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign accept    = item_valid && item_ready;

    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_write)
        begin
            case (paddr[3:2])
                REG_IDX_SECTION: limits_next.sec   = pwdata[7:0];
                REG_IDX_NAME:    limits_next.name  = pwdata[7:0];
                REG_IDX_VALUE:   limits_next.value = pwdata[11:0];
                default:         limits_next       = limits_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_IDX_SECTION: prdata = {24'd0, limits_reg.sec};
            REG_IDX_NAME:    prdata = {24'd0, limits_reg.name};
            REG_IDX_VALUE:   prdata = {20'd0, limits_reg.value};
            default:         prdata = 32'd0;
        endcase
    end

    ict_step u_step
    (
        .cur       (state_reg),
        .func      (func),
        .data_byte (data_byte),
        .limits    (limits_reg),
        .nxt       (step_nxt),
        .res_n     (step_res_n),
        .res0      (step_res0),
        .res1      (step_res1)
    );

    assign state_next = accept ? step_nxt : state_reg;
    assign push_n     = accept ? step_res_n : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= PARSE_STATE_RESET;
            limits_reg <= LIMITS_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            limits_reg <= limits_next;
        end
    end

    ict_res_fifo u_res_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_n     (push_n),
        .push0      (step_res0),
        .push1      (step_res1),
        .room       (item_ready),
        .head       (head),
        .head_valid (result_valid),
        .head_ready (result_ready)
    );

    assign kind          = head.kind;
    assign out_char      = head.ch;
    assign error_code    = head.code;
    assign line_number   = head.line;
    assign column_number = head.col;
    assign byte_offset   = head.bytes;
    assign last_of_run   = head.last;

    `ICT_ASSERT_NEXT(a_eos_restart, accept && func, state_reg == PARSE_STATE_RESET, "parse state not restarted after end of stream")
    `ICT_ASSERT_NEXT(a_failed_holds, accept && !func && state_reg.failed, $stable(state_reg), "state moved after failure")
    `ICT_ASSERT_SAME(a_pair_only_eos, accept && step_res_n == 2'd2, func, "two events from a data byte")

endmodule

`default_nettype wire

FILE: tb/ict_tb_pkg.sv
// codes and character constants shared by the tokenizer testbench files
// no dependencies
package ict_tb_pkg;

    // item channel operations
    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // result kinds
    localparam logic [2:0] KIND_SEC_CHAR   = 3'd0;
    localparam logic [2:0] KIND_SEC_END    = 3'd1;
    localparam logic [2:0] KIND_NAME_CHAR  = 3'd2;
    localparam logic [2:0] KIND_VAL_CHAR   = 3'd3;
    localparam logic [2:0] KIND_ENTRY_END  = 3'd4;
    localparam logic [2:0] KIND_ERROR      = 3'd5;
    localparam logic [2:0] KIND_DONE       = 3'd6;

    // error codes
    localparam logic [2:0] CODE_NONE       = 3'd0;
    localparam logic [2:0] ERR_ILLEGAL     = 3'd0;
    localparam logic [2:0] ERR_EQUALS      = 3'd1;
    localparam logic [2:0] ERR_QUOTE       = 3'd2;
    localparam logic [2:0] ERR_TOO_LONG    = 3'd3;
    localparam logic [2:0] ERR_HEADER      = 3'd4;

    // characters with a meaning to the tokenizer
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

endpackage

FILE: tb/ini_config_tokenizer_core_checker.sv
// event predictor and scoreboard for the ini config tokenizer
// watches the item, result and apb channels; depends on ict_pkg and ict_tb_pkg
module ini_config_tokenizer_core_checker
    import ict_pkg::*;
    import ict_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    input  logic        item_ready,
    input  logic        func,
    input  logic [7:0]  data_byte,

    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [2:0]  kind,
    input  logic [7:0]  out_char,
    input  logic [2:0]  error_code,
    input  logic [23:0] line_number,
    input  logic [15:0] column_number,
    input  logic [31:0] byte_offset,
    input  logic        last_of_run,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,

    output int          mismatches,
    output int          outstanding,
    output int          events_checked,
    output int          error_events
);

    phase_t      phase;
    logic [11:0] tok_len;
    logic [23:0] line_cnt;
    logic [15:0] col_cnt;
    logic [31:0] byte_cnt;
    logic        failed;
    limits_t     limits;

    result_t     token_events[$];
    int          mismatch_total;
    int          checked_total;
    int          error_total;

    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR
            || c == CH_FF || c == CH_VT;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic bit is_name_char(logic [7:0] c);
        return is_letter(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_USCORE;
    endfunction

    function automatic void restart_stream();
        phase    = PH_TOP;
        tok_len  = '0;
        line_cnt = 24'd1;
        col_cnt  = '0;
        byte_cnt = '0;
        failed   = 1'b0;
    endfunction

    // every event carries the position after the current byte
    function automatic result_t position_event(logic [2:0] k, logic [7:0] ch,
                                               logic [2:0] code);
        result_t r;
        r.kind  = k;
        r.ch    = ch;
        r.code  = code;
        r.line  = line_cnt;
        r.col   = col_cnt;
        r.bytes = byte_cnt;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic result_t raise_error(logic [2:0] code);
        failed = 1'b1;
        return position_event(KIND_ERROR, 8'd0, code);
    endfunction

    function automatic result_t take_char(logic [2:0] k, logic [7:0] ch,
                                          logic [11:0] limit);
        if (tok_len < limit)
        begin
            tok_len = tok_len + 12'd1;
            return position_event(k, ch, CODE_NONE);
        end
        return raise_error(ERR_TOO_LONG);
    endfunction

    function automatic void tokenize(logic f, logic [7:0] c);
        result_t evs[$];
        if (f == FUNC_END)
        begin
            if (!failed)
            begin
                case (phase)
                    PH_TOP, PH_COMMENT: ;
                    PH_HDR_PRE, PH_HDR_NAME, PH_HDR_POST:
                        evs.push_back(raise_error(ERR_HEADER));
                    PH_NAME, PH_NAME_POST:
                        evs.push_back(raise_error(ERR_EQUALS));
                    default:
                        evs.push_back(raise_error(ERR_QUOTE));
                endcase
            end
            evs.push_back(position_event(KIND_DONE, 8'd0, CODE_NONE));
            restart_stream();
        end
        else if (!failed)
        begin
            if (byte_cnt != '1)
                byte_cnt = byte_cnt + 32'd1;
            if (col_cnt != '1)
                col_cnt = col_cnt + 16'd1;
            if (c == CH_NL)
            begin
                if (line_cnt != '1)
                    line_cnt = line_cnt + 24'd1;
                col_cnt = '0;
            end

            case (phase)
                PH_TOP:
                begin
                    if (is_space(c))
                        ;
                    else if (c == CH_LBRACK)
                        phase = PH_HDR_PRE;
                    else if (c == CH_HASH)
                        phase = PH_COMMENT;
                    else if (is_letter(c))
                    begin
                        tok_len = '0;
                        phase = PH_NAME;
                        evs.push_back(take_char(KIND_NAME_CHAR, c, {4'd0, limits.name}));
                    end
                    else
                        evs.push_back(raise_error(ERR_ILLEGAL));
                end
                PH_HDR_PRE:
                begin
                    if (is_space(c))
                        ;
                    else if (is_letter(c))
                    begin
                        tok_len = '0;
                        phase = PH_HDR_NAME;
                        evs.push_back(take_char(KIND_SEC_CHAR, c, {4'd0, limits.sec}));
                    end
                    else
                        evs.push_back(raise_error(ERR_HEADER));
                end
                PH_HDR_NAME, PH_HDR_POST:
                begin
                    if (phase == PH_HDR_NAME && is_name_char(c))
                        evs.push_back(take_char(KIND_SEC_CHAR, c, {4'd0, limits.sec}));
                    else if (is_space(c))
                        phase = PH_HDR_POST;
                    else if (c == CH_RBRACK)
                    begin
                        evs.push_back(position_event(KIND_SEC_END, 8'd0, CODE_NONE));
                        phase = PH_TOP;
                    end
                    else
                        evs.push_back(raise_error(ERR_HEADER));
                end
                PH_NAME, PH_NAME_POST:
                begin
                    if (phase == PH_NAME && is_name_char(c))
                        evs.push_back(take_char(KIND_NAME_CHAR, c, {4'd0, limits.name}));
                    else if (is_space(c))
                        phase = PH_NAME_POST;
                    else if (c == CH_EQUALS)
                        phase = PH_VAL_PRE;
                    else
                        evs.push_back(raise_error(ERR_EQUALS));
                end
                PH_VAL_PRE:
                begin
                    if (is_space(c))
                        ;
                    else if (c == CH_QUOTE)
                    begin
                        tok_len = '0;
                        phase = PH_VALUE;
                    end
                    else
                        evs.push_back(raise_error(ERR_QUOTE));
                end
                PH_VALUE:
                begin
                    if (c == CH_BSLASH)
                        phase = PH_ESC;
                    else if (c == CH_QUOTE)
                    begin
                        evs.push_back(position_event(KIND_ENTRY_END, 8'd0, CODE_NONE));
                        phase = PH_TOP;
                    end
                    else
                        evs.push_back(take_char(KIND_VAL_CHAR, c, limits.value));
                end
                PH_ESC:
                begin
                    if (c == CH_BSLASH || c == CH_QUOTE)
                    begin
                        phase = PH_VALUE;
                        evs.push_back(take_char(KIND_VAL_CHAR, c, limits.value));
                    end
                    else
                        evs.push_back(raise_error(ERR_ILLEGAL));
                end
                default:
                    // comment runs to end of line
                    phase = (c == CH_NL) ? PH_TOP : PH_COMMENT;
            endcase
        end

        if (evs.size() > 0)
            evs[evs.size() - 1].last = 1'b1;
        foreach (evs[i])
            token_events.push_back(evs[i]);
    endfunction

    function automatic void check_field(string label, logic [31:0] want,
                                        logic [31:0] got);
        if (got !== want)
        begin
            mismatch_total++;
            $display("%0t: mismatch on %s: expected %0h, actual %0h",
                     $time, label, want, got);
        end
    endfunction

    function automatic void compare_event();
        result_t want;
        checked_total++;
        if (kind == KIND_ERROR)
            error_total++;
        if (token_events.size() == 0)
        begin
            mismatch_total++;
            $display("%0t: mismatch: expected no event, actual kind %0d char %0h code %0d",
                     $time, kind, out_char, error_code);
            return;
        end
        want = token_events.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind));
        check_field("out_char", 32'(want.ch), 32'(out_char));
        check_field("error_code", 32'(want.code), 32'(error_code));
        check_field("line_number", 32'(want.line), 32'(line_number));
        check_field("column_number", 32'(want.col), 32'(column_number));
        check_field("byte_offset", want.bytes, byte_offset);
        check_field("last_of_run", 32'(want.last), 32'(last_of_run));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_stream();
            limits = LIMITS_RESET;
            token_events.delete();
            mismatch_total = 0;
            checked_total = 0;
            error_total = 0;
            mismatches <= 0;
            outstanding <= 0;
            events_checked <= 0;
            error_events <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
                compare_event();
            if (item_valid && item_ready)
                tokenize(func, data_byte);
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_IDX_SECTION: limits.sec = pwdata[7:0];
                    REG_IDX_NAME:    limits.name = pwdata[7:0];
                    REG_IDX_VALUE:   limits.value = pwdata[11:0];
                    default: ;
                endcase
            end
            mismatches <= mismatch_total;
            outstanding <= token_events.size();
            events_checked <= checked_total;
            error_events <= error_total;
        end
    end

endmodule

FILE: tb/ini_config_tokenizer_core_tb.sv
// top of the ini config tokenizer testbench: clock, reset, stream stimulus, verdict
// depends on ict_pkg, ict_tb_pkg, the checker module and the tokenizer rtl
module ini_config_tokenizer_core_tb;
    import ict_pkg::*;
    import ict_tb_pkg::*;

    localparam int CLK_PERIOD        = 12;
    localparam int MAX_WAIT          = 17;
    localparam int SETTLE_CYCLES     = 4;
    localparam int HOLD_OFF_CYCLES   = 240;
    localparam int TARGET_ITEMS      = 1400;
    localparam int STREAMS_PER_BLOCK = 6;
    localparam int TIMEOUT_CYCLES    = 600000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        item_valid = 1'b0;
    logic        item_ready;
    logic        func = FUNC_DATA;
    logic [7:0]  data_byte = 8'd0;

    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  out_char;
    logic [2:0]  error_code;
    logic [23:0] line_number;
    logic [15:0] column_number;
    logic [31:0] byte_offset;
    logic        last_of_run;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          outstanding;
    int          events_checked;
    int          error_events;

    logic [7:0]  stream_bytes[$];
    limits_t     cur_limits = LIMITS_RESET;
    int          items_sent = 0;
    int          streams_sent = 0;
    int          settings_applied = 0;
    bit          sender_eager = 1'b0;
    bit          hold_off_req = 1'b0;

    ini_config_tokenizer_core dut (.*);

    ini_config_tokenizer_core_checker chk (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------- stream generation ----------------

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? 8'h41 : 8'h61;
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_name_char();
        int pick;
        pick = $urandom_range(0, 62);
        if (pick < 52)
            return rand_letter();
        if (pick < 62)
            return 8'h30 + 8'(pick - 52);
        return CH_USCORE;
    endfunction

    function automatic logic [7:0] rand_space();
        case ($urandom_range(0, 9))
            0: return CH_TAB;
            1: return CH_NL;
            2: return CH_CR;
            3: return CH_FF;
            4: return CH_VT;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic void add_gap();
        repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0)
            stream_bytes.push_back(rand_space());
    endfunction

    // mostly short tokens, now and then one at or just past a small enough limit
    function automatic int token_size(int limit);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3 && limit <= 300)
            return limit + $urandom_range(0, 1);
        if (pick < 12)
            return $urandom_range(1, 20);
        return $urandom_range(1, 6);
    endfunction

    function automatic void add_name(int limit);
        int len;
        len = token_size(limit);
        stream_bytes.push_back(rand_letter());
        for (int i = 1; i < len; i++)
            stream_bytes.push_back(rand_name_char());
    endfunction

    function automatic void add_value(int limit);
        int len;
        int pick;
        logic [7:0] b;
        len = ($urandom_range(0, 9) == 0) ? 0 : token_size(limit);
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 49);
            if (pick < 4)
            begin
                stream_bytes.push_back(CH_BSLASH);
                stream_bytes.push_back((pick < 2) ? CH_BSLASH : CH_QUOTE);
            end
            else if (pick == 4)
            begin
                // escape with an arbitrary second byte, usually illegal
                stream_bytes.push_back(CH_BSLASH);
                stream_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_BSLASH || b == CH_QUOTE)
                    b = CH_USCORE;
                stream_bytes.push_back(b);
            end
        end
    endfunction

    function automatic void add_section();
        stream_bytes.push_back(CH_LBRACK);
        add_gap();
        add_name(int'(cur_limits.sec));
        add_gap();
        stream_bytes.push_back(CH_RBRACK);
    endfunction

    function automatic void add_entry();
        add_name(int'(cur_limits.name));
        add_gap();
        stream_bytes.push_back(CH_EQUALS);
        add_gap();
        stream_bytes.push_back(CH_QUOTE);
        add_value(int'(cur_limits.value));
        stream_bytes.push_back(CH_QUOTE);
    endfunction

    function automatic void add_comment();
        logic [7:0] b;
        stream_bytes.push_back(CH_HASH);
        repeat ($urandom_range(0, 8))
        begin
            b = 8'($urandom_range(0, 255));
            stream_bytes.push_back((b == CH_NL) ? CH_SPACE : b);
        end
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            stream_bytes.push_back(s[i]);
    endfunction

    function automatic void build_stream();
        int lines;
        int cut;
        int pos;
        stream_bytes.delete();
        lines = $urandom_range(1, 6);
        for (int i = 0; i < lines; i++)
        begin
            add_gap();
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5:                 add_section();
                6, 7, 8, 9, 10, 11, 12, 13:       add_entry();
                14, 15, 16:                       add_comment();
                17, 18:                           ;
                default: stream_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
            // the last line may end without a newline
            if (i < lines - 1 || $urandom_range(0, 2) != 0)
                stream_bytes.push_back(CH_NL);
        end
        case ($urandom_range(0, 9))
            0:
            begin
                // stream cut short anywhere
                cut = $urandom_range(0, stream_bytes.size());
                while (stream_bytes.size() > cut)
                    void'(stream_bytes.pop_back());
            end
            1:
            begin
                // stray byte, followed by at most three bytes that are ignored if it raised an error
                pos = $urandom_range(0, stream_bytes.size());
                stream_bytes.insert(pos, 8'($urandom_range(0, 255)));
                cut = pos + 1 + $urandom_range(0, 3);
                while (stream_bytes.size() > cut)
                    void'(stream_bytes.pop_back());
            end
            default: ;
        endcase
    endfunction

    // ---------------- channel drivers ----------------

    task automatic send_item(input logic f, input logic [7:0] b);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        func <= f;
        data_byte <= b;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_stream();
        foreach (stream_bytes[i])
            send_item(FUNC_DATA, stream_bytes[i]);
        send_item(FUNC_END, 8'($urandom_range(0, 255)));
        streams_sent++;
    endtask

    // called at the edge that took the last transaction
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_limits(input limits_t setting);
        drain();
        write_limit(REG_IDX_SECTION, {24'd0, setting.sec});
        write_limit(REG_IDX_NAME, {24'd0, setting.name});
        write_limit(REG_IDX_VALUE, {20'd0, setting.value});
        cur_limits = setting;
        settings_applied++;
    endtask

    // receiver: random stalls, eager stretches, and a long hold-off on request
    initial
    begin
        int stall;
        bit eager;
        eager = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 39) == 0)
                    eager = !eager;
                stall = eager ? 0 : $urandom_range(0, MAX_WAIT);
                if (stall > 0)
                begin
                    result_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("ini_config_tokenizer_core_tb NOT OK");
        $finish;
    end

    initial
    begin
        limits_t setting;
        int block;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // header, entry with empty value, comment left open at end of stream
        stream_bytes.delete();
        add_text("[a]k=\"\"#");
        send_stream();
        // both escapes and a top-bit byte inside a value
        stream_bytes.delete();
        add_text("v=\"\\\\\\\"");
        stream_bytes.push_back(8'hFF);
        add_text("\"");
        send_stream();
        // stray byte at top level, then a byte that is ignored
        stream_bytes.delete();
        stream_bytes.push_back(8'h00);
        add_text("x");
        send_stream();
        // end of stream inside a header
        stream_bytes.delete();
        add_text("[");
        send_stream();
        // bad escape
        stream_bytes.delete();
        add_text("n=\"\\q");
        send_stream();

        block = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            case (block)
                0: setting = '{sec: 8'd1, name: 8'd1, value: 12'd1};
                1: setting = '{sec: 8'd255, name: 8'd255, value: 12'd4095};
                2: setting = LIMITS_RESET;
                default:
                    if ($urandom_range(0, 1))
                        setting = '{sec: 8'($urandom_range(1, 8)),
                                    name: 8'($urandom_range(1, 8)),
                                    value: 12'($urandom_range(1, 8))};
                    else
                        setting = '{sec: 8'($urandom_range(1, 255)),
                                    name: 8'($urandom_range(1, 255)),
                                    value: 12'($urandom_range(1, 4095))};
            endcase
            apply_limits(setting);
            for (int s = 0; s < STREAMS_PER_BLOCK; s++)
            begin
                // receiver holds off while the sender keeps pushing
                if (s == 0 && block % 2 == 1)
                    hold_off_req = 1'b1;
                sender_eager = (s == 0 && block % 2 == 1) || ($urandom_range(0, 3) == 0);
                build_stream();
                send_stream();
            end
            block++;
        end

        drain();
        $display("run covered %0d input transactions in %0d streams under %0d limit settings",
                 items_sent, streams_sent, settings_applied);
        $display("%0d result transactions checked, %0d of them error reports",
                 events_checked, error_events);
        if (mismatches == 0 && outstanding == 0)
            $display("ini_config_tokenizer_core_tb OK");
        else
            $display("ini_config_tokenizer_core_tb NOT OK");
        $finish;
    end

endmodule
